>>> design/assert_macros.svh
// Assertion macros used by the checker file of the style mapper.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that stays active through reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> design/mams_pkg.sv
// Types, codes and constant tables for the math alphanumeric style mapper.
// Depends on nothing; used by all stage modules and the top level.
`default_nettype none

package mams_pkg;

   localparam int CP_W = 21;

   // font style codes
   localparam logic [3:0] STYLE_NONE     = 4'd0;
   localparam logic [3:0] STYLE_RM       = 4'd1;
   localparam logic [3:0] STYLE_BF       = 4'd2;
   localparam logic [3:0] STYLE_IT       = 4'd3;
   localparam logic [3:0] STYLE_BFIT     = 4'd9;
   localparam logic [3:0] STYLE_SFBF     = 4'd12;
   localparam logic [3:0] STYLE_SFBFIT   = 4'd14;
   localparam logic [3:0] STYLE_UNLISTED = 4'd15;

   // math convention codes
   localparam logic [1:0] CONV_TEX     = 2'd0;
   localparam logic [1:0] CONV_ISO     = 2'd1;
   localparam logic [1:0] CONV_FRENCH  = 2'd2;
   localparam logic [1:0] CONV_UPRIGHT = 2'd3;

   // character classes
   localparam logic [2:0] CLS_DIGIT       = 3'd0;
   localparam logic [2:0] CLS_LATIN_SMALL = 3'd1;
   localparam logic [2:0] CLS_LATIN_CAP   = 3'd2;
   localparam logic [2:0] CLS_GREEK_SMALL = 3'd3;
   localparam logic [2:0] CLS_GREEK_CAP   = 3'd4;

   localparam int NUM_ORPHANS  = 13;
   localparam int NUM_RESERVED = 24;

   localparam logic [CP_W-1:0] STYLE_BASE [15][5] = '{
      '{21'h0,     21'h0,     21'h0,     21'h0,     21'h0},
      '{21'h30,    21'h61,    21'h41,    21'h03B1,  21'h0391},
      '{21'h1D7CE, 21'h1D41A, 21'h1D400, 21'h1D6C2, 21'h1D6A8},
      '{21'h30,    21'h1D44E, 21'h1D434, 21'h1D6FC, 21'h1D6E2},
      '{21'h30,    21'h1D4B6, 21'h1D49C, 21'h03B1,  21'h0391},
      '{21'h30,    21'h1D51E, 21'h1D504, 21'h03B1,  21'h0391},
      '{21'h1D7D8, 21'h1D552, 21'h1D538, 21'h03B1,  21'h0391},
      '{21'h1D7E2, 21'h1D5BA, 21'h1D5A0, 21'h03B1,  21'h0391},
      '{21'h1D7F6, 21'h1D68A, 21'h1D670, 21'h03B1,  21'h0391},
      '{21'h30,    21'h1D482, 21'h1D468, 21'h1D736, 21'h1D71C},
      '{21'h30,    21'h1D4EA, 21'h1D4D0, 21'h03B1,  21'h0391},
      '{21'h30,    21'h1D586, 21'h1D56C, 21'h03B1,  21'h0391},
      '{21'h1D7EC, 21'h1D5EE, 21'h1D5D4, 21'h1D770, 21'h1D756},
      '{21'h30,    21'h1D622, 21'h1D608, 21'h03B1,  21'h0391},
      '{21'h30,    21'h1D656, 21'h1D63C, 21'h1D7AA, 21'h1D790}
   };

   localparam logic [CP_W-1:0] CONV_BASE [4][5] = '{
      '{21'h30, 21'h1D44E, 21'h1D434, 21'h1D6FC, 21'h0391},
      '{21'h30, 21'h1D44E, 21'h1D434, 21'h1D6FC, 21'h1D6E2},
      '{21'h30, 21'h1D44E, 21'h41,    21'h03B1,  21'h0391},
      '{21'h30, 21'h61,    21'h41,    21'h03B1,  21'h0391}
   };

   localparam logic [CP_W-1:0] HOLE_FROM [NUM_RESERVED] = '{
      21'h1D455, 21'h1D49D, 21'h1D4A0, 21'h1D4A1, 21'h1D4A3, 21'h1D4A4,
      21'h1D4A7, 21'h1D4A8, 21'h1D4AD, 21'h1D4BA, 21'h1D4BC, 21'h1D4C4,
      21'h1D506, 21'h1D50B, 21'h1D50C, 21'h1D515, 21'h1D51D, 21'h1D53A,
      21'h1D53F, 21'h1D545, 21'h1D547, 21'h1D548, 21'h1D549, 21'h1D551
   };

   localparam logic [CP_W-1:0] HOLE_TO [NUM_RESERVED] = '{
      21'h210E, 21'h212C, 21'h2130, 21'h2131, 21'h210B, 21'h2110,
      21'h2112, 21'h2133, 21'h211B, 21'h212F, 21'h210A, 21'h2134,
      21'h212D, 21'h210C, 21'h2111, 21'h211C, 21'h2128, 21'h2102,
      21'h210D, 21'h2115, 21'h2119, 21'h211A, 21'h211D, 21'h2124
   };

   localparam logic [CP_W-1:0] ORPHAN_CODE [NUM_ORPHANS] = '{
      21'h131, 21'h237, 21'h3D1, 21'h3D5, 21'h3D6, 21'h3DC, 21'h3DD,
      21'h3F0, 21'h3F1, 21'h3F4, 21'h3F5, 21'h2202, 21'h2207
   };

   // orphan kind uses the class codes: latin small, greek small, greek capital
   localparam logic [2:0] ORPHAN_KIND [NUM_ORPHANS] = '{
      CLS_LATIN_SMALL, CLS_LATIN_SMALL, CLS_GREEK_SMALL, CLS_GREEK_SMALL,
      CLS_GREEK_SMALL, CLS_GREEK_CAP,   CLS_GREEK_SMALL, CLS_GREEK_SMALL,
      CLS_GREEK_SMALL, CLS_GREEK_CAP,   CLS_GREEK_SMALL, CLS_GREEK_SMALL,
      CLS_GREEK_CAP
   };

   // columns: rm, bf, it, bfit, sfbf, sfbfit; zero means no target
   localparam logic [CP_W-1:0] ORPHAN_TARGET [NUM_ORPHANS][6] = '{
      '{21'h131,  21'h0,     21'h1D6A4, 21'h0,     21'h0,     21'h0},
      '{21'h237,  21'h0,     21'h1D6A5, 21'h0,     21'h0,     21'h0},
      '{21'h3D1,  21'h1D6DD, 21'h1D717, 21'h1D751, 21'h1D78B, 21'h1D7C5},
      '{21'h3D5,  21'h1D6DF, 21'h1D719, 21'h1D753, 21'h1D78D, 21'h1D7C7},
      '{21'h3D6,  21'h1D6E1, 21'h1D71B, 21'h1D755, 21'h1D78F, 21'h1D7C9},
      '{21'h3DC,  21'h1D7CA, 21'h0,     21'h0,     21'h0,     21'h0},
      '{21'h3DD,  21'h1D7CB, 21'h0,     21'h0,     21'h0,     21'h0},
      '{21'h3F0,  21'h1D6DE, 21'h1D718, 21'h1D752, 21'h1D78C, 21'h1D7C6},
      '{21'h3F1,  21'h1D6E0, 21'h1D71A, 21'h1D754, 21'h1D78E, 21'h1D7C8},
      '{21'h3F4,  21'h1D6B9, 21'h1D6F3, 21'h1D72D, 21'h1D767, 21'h1D7A1},
      '{21'h3F5,  21'h1D6DC, 21'h1D716, 21'h1D750, 21'h1D78A, 21'h1D7C4},
      '{21'h2202, 21'h1D6DB, 21'h1D715, 21'h1D74F, 21'h1D789, 21'h1D7C3},
      '{21'h2207, 21'h1D6C1, 21'h1D6FB, 21'h1D735, 21'h1D76F, 21'h1D7A9}
   };

   // payload between classify and map stages
   typedef struct packed {
      logic            bypass;
      logic            classed;
      logic            orphan;
      logic [3:0]      orphan_idx;
      logic [3:0]      orphan_style;
      logic [4:0]      offset;
      logic [CP_W-1:0] base;
      logic [CP_W-1:0] code_point;
   } cls_type;

   // payload between map and hole stages
   typedef struct packed {
      logic            done;
      logic [CP_W-1:0] value;
   } map_type;

endpackage

`default_nettype wire

>>> design/mams_classify.sv
// Stage one: classify the code point, pick the style base, match orphans.
// Depends on mams_pkg.
`default_nettype none

module mams_classify (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [1:0]                conv,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [3:0]                font_style,
   input  wire logic [mams_pkg::CP_W-1:0] code_point,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output mams_pkg::cls_type              out_data
);

   logic                      valid_ff;
   logic                      valid_in;
   mams_pkg::cls_type         data_ff;
   mams_pkg::cls_type         data_in;
   logic [2:0]                cls;
   logic [2:0]                kind;
   logic [mams_pkg::CP_W-1:0] low;
   logic [mams_pkg::CP_W-1:0] diff;

   // classify and look up the base
   always_comb begin
      data_in            = '0;
      data_in.code_point = code_point;
      data_in.bypass     = (font_style == mams_pkg::STYLE_UNLISTED);
      cls                = mams_pkg::CLS_DIGIT;
      low                = '0;
      kind               = mams_pkg::CLS_LATIN_SMALL;
      data_in.classed    = 1'b1;
      if (code_point inside {[21'h30 : 21'h39]}) begin
         cls = mams_pkg::CLS_DIGIT;
         low = 21'h30;
      end else if (code_point inside {[21'h61 : 21'h7A]}) begin
         cls = mams_pkg::CLS_LATIN_SMALL;
         low = 21'h61;
      end else if (code_point inside {[21'h41 : 21'h5A]}) begin
         cls = mams_pkg::CLS_LATIN_CAP;
         low = 21'h41;
      end else if (code_point inside {[21'h3B1 : 21'h3C9]}) begin
         cls = mams_pkg::CLS_GREEK_SMALL;
         low = 21'h3B1;
      end else if (code_point inside {[21'h391 : 21'h3A9]}) begin
         cls = mams_pkg::CLS_GREEK_CAP;
         low = 21'h391;
      end else begin
         data_in.classed = 1'b0;
      end
      diff           = code_point - low;
      data_in.offset = diff[4:0];

      if (font_style == mams_pkg::STYLE_NONE) begin
         data_in.base = mams_pkg::CONV_BASE[conv][cls];
      end else if (!data_in.bypass) begin
         data_in.base = mams_pkg::STYLE_BASE[font_style][cls];
      end

      // match the orphan symbols
      for (int i = 0; i < mams_pkg::NUM_ORPHANS; i++) begin
         if (code_point == mams_pkg::ORPHAN_CODE[i]) begin
            data_in.orphan     = 1'b1;
            data_in.orphan_idx = 4'(i);
            kind               = mams_pkg::ORPHAN_KIND[i];
         end
      end

      // resolve style none for orphans from the convention
      data_in.orphan_style = font_style;
      if (font_style == mams_pkg::STYLE_NONE) begin
         case (kind)
            mams_pkg::CLS_LATIN_SMALL:
               data_in.orphan_style = (conv == mams_pkg::CONV_UPRIGHT) ?
                                      mams_pkg::STYLE_RM : mams_pkg::STYLE_IT;
            mams_pkg::CLS_GREEK_SMALL:
               data_in.orphan_style = (conv inside {mams_pkg::CONV_FRENCH,
                                                    mams_pkg::CONV_UPRIGHT}) ?
                                      mams_pkg::STYLE_RM : mams_pkg::STYLE_IT;
            default:
               data_in.orphan_style = (conv == mams_pkg::CONV_ISO) ?
                                      mams_pkg::STYLE_IT : mams_pkg::STYLE_RM;
         endcase
      end
   end

   // advance when empty or when the next stage can take the transaction
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> design/mams_map.sv
// Stage two: add the letter offset to the base or select the orphan target.
// Depends on mams_pkg.
`default_nettype none

module mams_map (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire mams_pkg::cls_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output mams_pkg::map_type out_data
);

   logic                      valid_ff;
   logic                      valid_in;
   mams_pkg::map_type         data_ff;
   mams_pkg::map_type         data_in;
   logic                      col_ok;
   logic [2:0]                col;
   logic [mams_pkg::CP_W-1:0] target;

   // pick the target column of the orphan table
   always_comb begin
      col_ok = 1'b1;
      col    = 3'd0;
      case (in_data.orphan_style)
         mams_pkg::STYLE_RM:     col = 3'd0;
         mams_pkg::STYLE_BF:     col = 3'd1;
         mams_pkg::STYLE_IT:     col = 3'd2;
         mams_pkg::STYLE_BFIT:   col = 3'd3;
         mams_pkg::STYLE_SFBF:   col = 3'd4;
         mams_pkg::STYLE_SFBFIT: col = 3'd5;
         default:                col_ok = 1'b0;
      endcase
      target = in_data.orphan ? mams_pkg::ORPHAN_TARGET[in_data.orphan_idx][col] : '0;
   end

   // form the mapped value; done marks results that skip the hole table
   always_comb begin
      data_in.done  = 1'b0;
      data_in.value = in_data.code_point;
      if (in_data.bypass) begin
         data_in.done = 1'b1;
      end else if (in_data.classed) begin
         data_in.value = in_data.base + {16'b0, in_data.offset};
      end else if (in_data.orphan) begin
         data_in.done = 1'b1;
         if (col_ok && target != '0) begin
            data_in.value = target;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> design/mams_hole.sv
// Stage three: replace results that land in a reserved hole; output register.
// Depends on mams_pkg.
`default_nettype none

module mams_hole (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire mams_pkg::map_type         in_data,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic [mams_pkg::CP_W-1:0]      out_code_point
);

   logic                      valid_ff;
   logic                      valid_in;
   logic [mams_pkg::CP_W-1:0] data_ff;
   logic [mams_pkg::CP_W-1:0] data_in;

   // look up the reserved table
   always_comb begin
      data_in = in_data.value;
      if (!in_data.done) begin
         for (int i = 0; i < mams_pkg::NUM_RESERVED; i++) begin
            if (in_data.value == mams_pkg::HOLE_FROM[i]) begin
               data_in = mams_pkg::HOLE_TO[i];
            end
         end
      end
   end

   // hold the result until the consumer takes it
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid      = valid_ff;
   assign out_code_point = data_ff;

endmodule

`default_nettype wire

>>> design/math_alphanumeric_style_mapper.sv
// Math alphanumeric style mapper: three-stage pipeline (classify, map, hole).
// Each accepted request passes the classify, map and hole registers in order;
// rsp_valid rises once the hole register holds the result.
// Throughput: one transaction per cycle; each stage register stalls on its own.
// Reset: synchronous, clears all stage valid bits and sets the convention to TeX.
// Depends on mams_pkg, mams_classify, mams_map and mams_hole.
`default_nettype none

module math_alphanumeric_style_mapper (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_font_style,
   input  wire logic [20:0] req_code_point,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [20:0]      rsp_styled_code_point,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_write_data
);

   logic [1:0]        conv_reg_ff;
   logic [1:0]        conv_reg_in;
   logic              s1_valid;
   logic              s1_ready;
   mams_pkg::cls_type s1_data;
   logic              s2_valid;
   logic              s2_ready;
   mams_pkg::map_type s2_data;

   // hold the convention register
   assign conv_reg_in = csr_write_enable ? csr_write_data : conv_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_reg_ff <= mams_pkg::CONV_TEX;
      end else begin
         conv_reg_ff <= conv_reg_in;
      end
   end

   mams_classify u_classify (
      .clock      (clock),
      .reset      (reset),
      .conv       (conv_reg_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .font_style (req_font_style),
      .code_point (req_code_point),
      .out_valid  (s1_valid),
      .out_ready  (s1_ready),
      .out_data   (s1_data)
   );

   mams_map u_map (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   mams_hole u_hole (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s2_valid),
      .in_ready       (s2_ready),
      .in_data        (s2_data),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_code_point (rsp_styled_code_point)
   );

endmodule

`default_nettype wire

>>> design/mams_checker.sv
// Port-level checks of the style mapper, bound to the top level.
// Depends on assert_macros.svh, mams_pkg and math_alphanumeric_style_mapper.
`default_nettype none
`include "assert_macros.svh"

module mams_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [3:0]  req_font_style,
   input wire logic [20:0] req_code_point,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [20:0] rsp_styled_code_point
);

   logic        req_fire;
   logic        rsp_stall;
   logic        unlisted_fire;
   logic        bold_digit_fire;
   logic [20:0] req_cp;
   logic [20:0] rsp_cp;
   logic [20:0] bold_want;

   // qualify the transactions of interest
   assign req_fire        = req_valid && req_ready;
   assign rsp_stall       = rsp_valid && !rsp_ready;
   assign req_cp          = req_code_point;
   assign rsp_cp          = rsp_styled_code_point;
   assign unlisted_fire   = req_fire && (req_font_style == mams_pkg::STYLE_UNLISTED);
   assign bold_digit_fire = req_fire && (req_font_style == mams_pkg::STYLE_BF) &&
                            (req_cp >= 21'h30) && (req_cp <= 21'h39);
   // bold zero sits 0x1D79E above ASCII zero
   assign bold_want       = req_cp + 21'h1D79E;

   // accepted, then free flow at the output while the request moves through
   sequence unlisted_flow;
      unlisted_fire ##1 rsp_ready ##1 rsp_ready;
   endsequence

   sequence bold_digit_flow;
      bold_digit_fire ##1 rsp_ready ##1 rsp_ready;
   endsequence

   // a stalled result holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_cp))

   // no result directly after reset
   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid)

   // unlisted style passes the code point through unchanged under free flow
   `ASSERT_CLK(a_unlisted_pass, clock, reset, unlisted_flow |=> rsp_valid && rsp_cp == $past(req_cp, 3))

   // bold digits land in the bold digit block
   `ASSERT_CLK(a_bold_digit, clock, reset, bold_digit_flow |=> rsp_valid && rsp_cp == $past(bold_want, 3))

endmodule

bind math_alphanumeric_style_mapper mams_checker u_checker (.*);

`default_nettype wire

>>> verif/math_alphanumeric_style_mapper_tb.sv
// Self-checking testbench for math_alphanumeric_style_mapper: directed code points
// under TeX, random ones under every convention; all but the last phase idle at random.
// Depends on mams_pkg (convention codes) and the mapper RTL.
`default_nettype none

typedef enum logic [3:0] {
   FS_NONE, FS_RM, FS_BF, FS_IT, FS_CAL, FS_FRAK, FS_BB, FS_SF, FS_TT,
   FS_BFIT, FS_BFCAL, FS_BFFRAK, FS_SFBF, FS_SFIT, FS_SFBFIT, FS_UNLISTED
} font_style_type;

typedef enum logic [2:0] {
   CC_DIGIT, CC_LATIN_SMALL, CC_LATIN_CAP, CC_GREEK_SMALL, CC_GREEK_CAP, CC_OTHER
} char_class_type;

// Predicts the styled code point of each accepted transaction and checks results.
class styled_cp_tracker;
   logic [1:0]  convention;
   logic [20:0] expected_cp [$];
   int          errors;

   function new();
      convention = mams_pkg::CONV_TEX;
      errors     = 0;
   endfunction

   // style that stands in for style none, per class (orphans share the rule)
   function logic [3:0] style_for_none(char_class_type cc);
      case (cc)
         CC_LATIN_SMALL: return (convention == mams_pkg::CONV_UPRIGHT) ? FS_RM : FS_IT;
         CC_LATIN_CAP, CC_GREEK_SMALL:
            return (convention == mams_pkg::CONV_TEX || convention == mams_pkg::CONV_ISO)
                   ? FS_IT : FS_RM;
         CC_GREEK_CAP: return (convention == mams_pkg::CONV_ISO) ? FS_IT : FS_RM;
         default: return FS_RM;
      endcase
   endfunction

   function logic [20:0] class_base(logic [3:0] fs, char_class_type cc);
      case (cc)
         CC_DIGIT:
            case (fs)
               FS_BF:   return 21'h1D7CE;
               FS_BB:   return 21'h1D7D8;
               FS_SF:   return 21'h1D7E2;
               FS_TT:   return 21'h1D7F6;
               FS_SFBF: return 21'h1D7EC;
               default: return 21'h30;
            endcase
         CC_LATIN_SMALL:
            case (fs)
               FS_BF:     return 21'h1D41A;
               FS_IT:     return 21'h1D44E;
               FS_CAL:    return 21'h1D4B6;
               FS_FRAK:   return 21'h1D51E;
               FS_BB:     return 21'h1D552;
               FS_SF:     return 21'h1D5BA;
               FS_TT:     return 21'h1D68A;
               FS_BFIT:   return 21'h1D482;
               FS_BFCAL:  return 21'h1D4EA;
               FS_BFFRAK: return 21'h1D586;
               FS_SFBF:   return 21'h1D5EE;
               FS_SFIT:   return 21'h1D622;
               FS_SFBFIT: return 21'h1D656;
               default:   return 21'h61;
            endcase
         CC_LATIN_CAP:
            case (fs)
               FS_BF:     return 21'h1D400;
               FS_IT:     return 21'h1D434;
               FS_CAL:    return 21'h1D49C;
               FS_FRAK:   return 21'h1D504;
               FS_BB:     return 21'h1D538;
               FS_SF:     return 21'h1D5A0;
               FS_TT:     return 21'h1D670;
               FS_BFIT:   return 21'h1D468;
               FS_BFCAL:  return 21'h1D4D0;
               FS_BFFRAK: return 21'h1D56C;
               FS_SFBF:   return 21'h1D5D4;
               FS_SFIT:   return 21'h1D608;
               FS_SFBFIT: return 21'h1D63C;
               default:   return 21'h41;
            endcase
         CC_GREEK_SMALL:
            case (fs)
               FS_BF:     return 21'h1D6C2;
               FS_IT:     return 21'h1D6FC;
               FS_BFIT:   return 21'h1D736;
               FS_SFBF:   return 21'h1D770;
               FS_SFBFIT: return 21'h1D7AA;
               default:   return 21'h3B1;
            endcase
         default:
            case (fs)
               FS_BF:     return 21'h1D6A8;
               FS_IT:     return 21'h1D6E2;
               FS_BFIT:   return 21'h1D71C;
               FS_SFBF:   return 21'h1D756;
               FS_SFBFIT: return 21'h1D790;
               default:   return 21'h391;
            endcase
      endcase
   endfunction

   // column of the orphan target row, or -1 where the style has no column
   function int orphan_column(logic [3:0] fs);
      case (fs)
         FS_RM:     return 0;
         FS_BF:     return 1;
         FS_IT:     return 2;
         FS_BFIT:   return 3;
         FS_SFBF:   return 4;
         FS_SFBFIT: return 5;
         default:   return -1;
      endcase
   endfunction

   function bit orphan_kind(logic [20:0] cp, output char_class_type kind);
      kind = CC_OTHER;
      case (cp)
         21'h131, 21'h237:            kind = CC_LATIN_SMALL;
         21'h3DC, 21'h3F4, 21'h2207:  kind = CC_GREEK_CAP;
         21'h3D1, 21'h3D5, 21'h3D6, 21'h3DD, 21'h3F0, 21'h3F1, 21'h3F5, 21'h2202:
            kind = CC_GREEK_SMALL;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // zero means the orphan has no glyph in that style
   function logic [20:0] orphan_target(logic [20:0] cp, int col);
      logic [20:0] row [6];
      case (cp)
         21'h131:  row = '{21'h131,  21'h0,     21'h1D6A4, 21'h0,     21'h0,     21'h0};
         21'h237:  row = '{21'h237,  21'h0,     21'h1D6A5, 21'h0,     21'h0,     21'h0};
         21'h3D1:  row = '{21'h3D1,  21'h1D6DD, 21'h1D717, 21'h1D751, 21'h1D78B, 21'h1D7C5};
         21'h3D5:  row = '{21'h3D5,  21'h1D6DF, 21'h1D719, 21'h1D753, 21'h1D78D, 21'h1D7C7};
         21'h3D6:  row = '{21'h3D6,  21'h1D6E1, 21'h1D71B, 21'h1D755, 21'h1D78F, 21'h1D7C9};
         21'h3DC:  row = '{21'h3DC,  21'h1D7CA, 21'h0,     21'h0,     21'h0,     21'h0};
         21'h3DD:  row = '{21'h3DD,  21'h1D7CB, 21'h0,     21'h0,     21'h0,     21'h0};
         21'h3F0:  row = '{21'h3F0,  21'h1D6DE, 21'h1D718, 21'h1D752, 21'h1D78C, 21'h1D7C6};
         21'h3F1:  row = '{21'h3F1,  21'h1D6E0, 21'h1D71A, 21'h1D754, 21'h1D78E, 21'h1D7C8};
         21'h3F4:  row = '{21'h3F4,  21'h1D6B9, 21'h1D6F3, 21'h1D72D, 21'h1D767, 21'h1D7A1};
         21'h3F5:  row = '{21'h3F5,  21'h1D6DC, 21'h1D716, 21'h1D750, 21'h1D78A, 21'h1D7C4};
         21'h2202: row = '{21'h2202, 21'h1D6DB, 21'h1D715, 21'h1D74F, 21'h1D789, 21'h1D7C3};
         default:  row = '{21'h2207, 21'h1D6C1, 21'h1D6FB, 21'h1D735, 21'h1D76F, 21'h1D7A9};
      endcase
      return (col < 0) ? 21'h0 : row[col];
   endfunction

   // replace code points that fall into holes of the math alphanumeric block
   function logic [20:0] fill_hole(logic [20:0] cp);
      case (cp)
         21'h1D455: return 21'h210E;
         21'h1D49D: return 21'h212C;
         21'h1D4A0: return 21'h2130;
         21'h1D4A1: return 21'h2131;
         21'h1D4A3: return 21'h210B;
         21'h1D4A4: return 21'h2110;
         21'h1D4A7: return 21'h2112;
         21'h1D4A8: return 21'h2133;
         21'h1D4AD: return 21'h211B;
         21'h1D4BA: return 21'h212F;
         21'h1D4BC: return 21'h210A;
         21'h1D4C4: return 21'h2134;
         21'h1D506: return 21'h212D;
         21'h1D50B: return 21'h210C;
         21'h1D50C: return 21'h2111;
         21'h1D515: return 21'h211C;
         21'h1D51D: return 21'h2128;
         21'h1D53A: return 21'h2102;
         21'h1D53F: return 21'h210D;
         21'h1D545: return 21'h2115;
         21'h1D547: return 21'h2119;
         21'h1D548: return 21'h211A;
         21'h1D549: return 21'h211D;
         21'h1D551: return 21'h2124;
         default:   return cp;
      endcase
   endfunction

   function logic [20:0] restyle(logic [3:0] fs, logic [20:0] cp);
      char_class_type cc;
      char_class_type kind;
      logic [20:0] offset;
      logic [20:0] target;
      logic [3:0]  eff;
      if (fs == FS_UNLISTED) return cp;
      cc     = CC_OTHER;
      offset = 21'h0;
      if (cp >= 21'h30 && cp <= 21'h39) begin
         cc = CC_DIGIT;       offset = cp - 21'h30;
      end else if (cp >= 21'h61 && cp <= 21'h7A) begin
         cc = CC_LATIN_SMALL; offset = cp - 21'h61;
      end else if (cp >= 21'h41 && cp <= 21'h5A) begin
         cc = CC_LATIN_CAP;   offset = cp - 21'h41;
      end else if (cp >= 21'h3B1 && cp <= 21'h3C9) begin
         cc = CC_GREEK_SMALL; offset = cp - 21'h3B1;
      end else if (cp >= 21'h391 && cp <= 21'h3A9) begin
         cc = CC_GREEK_CAP;   offset = cp - 21'h391;
      end
      if (cc != CC_OTHER) begin
         eff = (fs == FS_NONE) ? style_for_none(cc) : fs;
         return fill_hole(class_base(eff, cc) + offset);
      end
      // orphans skip the hole table, missing targets pass through
      if (orphan_kind(cp, kind)) begin
         eff    = (fs == FS_NONE) ? style_for_none(kind) : fs;
         target = orphan_target(cp, orphan_column(eff));
         return (target == 21'h0) ? cp : target;
      end
      return fill_hole(cp);
   endfunction

   function void note_request(logic [3:0] fs, logic [20:0] cp);
      expected_cp.push_back(restyle(fs, cp));
   endfunction

   function void check_response(logic [20:0] got);
      logic [20:0] want;
      if (expected_cp.size() == 0) begin
         errors++;
         $display("%0t: unexpected styled_code_point %h, expected none", $time, got);
         return;
      end
      want = expected_cp.pop_front();
      if (got !== want) begin
         errors++;
         $display("%0t: styled_code_point expected %h actual %h", $time, want, got);
      end
   endfunction
endclass

module math_alphanumeric_style_mapper_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 90;

   localparam logic [3:0] DIR_STYLE [25] = '{
      FS_NONE, FS_UNLISTED, FS_UNLISTED, FS_BF, FS_TT, FS_NONE, FS_NONE, FS_IT,
      FS_CAL, FS_BB, FS_SFBFIT, FS_BFIT, FS_NONE, FS_SFBF, FS_NONE, FS_BF,
      FS_NONE, FS_SFBFIT, FS_IT, FS_FRAK, FS_RM, FS_NONE, FS_SFIT, FS_BFFRAK,
      FS_BFCAL
   };
   localparam logic [20:0] DIR_CP [25] = '{
      21'h0, 21'h1FFFFF, 21'h61, 21'h30, 21'h39, 21'h61, 21'h5A, 21'h68,
      21'h42, 21'h7A, 21'h3B1, 21'h3C9, 21'h391, 21'h3A9, 21'h131, 21'h131,
      21'h3F4, 21'h2207, 21'h3DC, 21'h3D1, 21'h1D455, 21'h110000, 21'h2202, 21'h41,
      21'h35
   };

   localparam logic [20:0] ORPHAN_CPS [13] = '{
      21'h131, 21'h237, 21'h3D1, 21'h3D5, 21'h3D6, 21'h3DC, 21'h3DD,
      21'h3F0, 21'h3F1, 21'h3F4, 21'h3F5, 21'h2202, 21'h2207
   };
   localparam logic [20:0] HOLE_CPS [24] = '{
      21'h1D455, 21'h1D49D, 21'h1D4A0, 21'h1D4A1, 21'h1D4A3, 21'h1D4A4,
      21'h1D4A7, 21'h1D4A8, 21'h1D4AD, 21'h1D4BA, 21'h1D4BC, 21'h1D4C4,
      21'h1D506, 21'h1D50B, 21'h1D50C, 21'h1D515, 21'h1D51D, 21'h1D53A,
      21'h1D53F, 21'h1D545, 21'h1D547, 21'h1D548, 21'h1D549, 21'h1D551
   };
   // just outside each class and some orphans, plus the edge of the Unicode range
   localparam logic [20:0] EDGE_CPS [18] = '{
      21'h2F, 21'h3A, 21'h40, 21'h5B, 21'h60, 21'h7B, 21'h390, 21'h3AA, 21'h3B0,
      21'h3CA, 21'h130, 21'h132, 21'h3DB, 21'h3DE, 21'h2201, 21'h2208,
      21'h10FFFF, 21'h110000
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [3:0]  req_font_style;
   logic [20:0] req_code_point;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [20:0] rsp_styled_code_point;
   logic        csr_write_enable;
   logic [1:0]  csr_write_data;

   int gap_pct;
   int stall_pct;
   int stall_left;
   int quiet_cycles;

   styled_cp_tracker tracker = new();

   math_alphanumeric_style_mapper dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_font_style        (req_font_style),
      .req_code_point        (req_code_point),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_styled_code_point (rsp_styled_code_point),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // record accepted requests first, then check any response on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_request(req_font_style, req_code_point);
         if (rsp_valid && rsp_ready) tracker.check_response(rsp_styled_code_point);
      end
   end

   // stall the response side in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   // end the run if neither channel moves a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL math_alphanumeric_style_mapper");
         $finish;
      end
   end

   // hold the request until accepted, then maybe leave a gap
   task automatic send_request(input logic [3:0] fs, input logic [20:0] cp);
      req_valid      <= 1'b1;
      req_font_style <= fs;
      req_code_point <= cp;
      do @(posedge clock); while (!req_ready);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.expected_cp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_convention(input logic [1:0] conv);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= conv;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.convention = conv;
   endtask

   // mostly classified letters and orphans, with holes, edges and raw noise
   task automatic random_request(output logic [3:0] fs, output logic [20:0] cp);
      int pick;
      pick = $urandom_range(0, 99);
      fs   = ($urandom_range(0, 3) == 0) ? FS_NONE : 4'($urandom_range(0, 15));
      if (pick < 12)
         cp = 21'h30 + 21'($urandom_range(0, 9));
      else if (pick < 26)
         cp = 21'h61 + 21'($urandom_range(0, 25));
      else if (pick < 38)
         cp = 21'h41 + 21'($urandom_range(0, 25));
      else if (pick < 50)
         cp = 21'h3B1 + 21'($urandom_range(0, 24));
      else if (pick < 60)
         cp = 21'h391 + 21'($urandom_range(0, 24));
      else if (pick < 78) begin
         cp = ORPHAN_CPS[$urandom_range(0, 12)];
         if ($urandom_range(0, 1) == 0) fs = FS_NONE;
      end else if (pick < 85)
         cp = HOLE_CPS[$urandom_range(0, 23)];
      else if (pick < 91)
         cp = EDGE_CPS[$urandom_range(0, 17)];
      else
         cp = 21'($urandom_range(0, 21'h1FFFFF));
   endtask

   task automatic random_phase(input int n);
      logic [3:0]  fs;
      logic [20:0] cp;
      repeat (n) begin
         random_request(fs, cp);
         send_request(fs, cp);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_font_style   = FS_NONE;
      req_code_point   = 21'h0;
      csr_write_enable = 1'b0;
      csr_write_data   = mams_pkg::CONV_TEX;
      gap_pct          = 25;
      stall_pct        = 25;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners under the reset convention
      foreach (DIR_CP[i]) send_request(DIR_STYLE[i], DIR_CP[i]);
      random_phase(ITEMS_PER_PHASE);

      set_convention(mams_pkg::CONV_ISO);
      gap_pct   = 0;
      stall_pct = 30;
      random_phase(ITEMS_PER_PHASE);

      set_convention(mams_pkg::CONV_FRENCH);
      gap_pct   = 30;
      stall_pct = 0;
      random_phase(ITEMS_PER_PHASE);

      set_convention(mams_pkg::CONV_UPRIGHT);
      gap_pct   = 20;
      stall_pct = 20;
      random_phase(ITEMS_PER_PHASE);

      // back to TeX at full rate with no idling
      set_convention(mams_pkg::CONV_TEX);
      gap_pct   = 0;
      stall_pct = 0;
      random_phase(ITEMS_PER_PHASE);

      req_valid <= 1'b0;
      while (tracker.expected_cp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0)
         $display("PASS math_alphanumeric_style_mapper");
      else
         $display("FAIL math_alphanumeric_style_mapper");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+design
design/mams_pkg.sv
design/mams_classify.sv
design/mams_map.sv
design/mams_hole.sv
design/math_alphanumeric_style_mapper.sv
design/mams_checker.sv
verif/math_alphanumeric_style_mapper_tb.sv
